// ===== src/m2h_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m2h_pkg
// Shared constants and types for the streaming MurmurHash2 block.
// ----------------------------------------------------------------------------
package m2h_pkg;

	localparam logic [31:0] MUL_K = 32'h5BD1E995;
	localparam int SHIFT_MIX = 24;
	localparam int SHIFT_FIN_A = 13;
	localparam int SHIFT_FIN_B = 15;

	localparam int FIFO_DEPTH_DEF = 4;

	// work to do for one word
	localparam logic [1:0] OP_NONE = 2'd0;
	localparam logic [1:0] OP_FULL = 2'd1;
	localparam logic [1:0] OP_TAIL = 2'd2;

	typedef struct packed {
		logic [31:0] word;    // tail bytes already masked
		logic [1:0]  op;
		logic        first;
		logic        last;
		logic [31:0] length;
	} m2h_entry_t;

	localparam int ENTRY_W = $bits(m2h_entry_t);

endpackage
`default_nettype wire

// ===== src/m2h_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m2h_front
// Accepts words, tracks message framing, drops stray words, classifies
// each word as full mix, tail or nothing and masks unused tail bytes.
// ----------------------------------------------------------------------------
module m2h_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_axis_tvalid,
	output logic                     s_axis_tready,
	input  wire logic [71:0]         s_axis_tdata,  // data_word, byte_count, total_length
	input  wire logic                s_axis_tuser,  // first_item
	input  wire logic                s_axis_tlast,  // last_item
	input  wire logic                q_full,
	output logic                     q_push,
	output m2h_pkg::m2h_entry_t      q_entry
);
	import m2h_pkg::*;

	logic        in_msg_q;
	logic        accept;
	logic        keep;
	logic [31:0] word;
	logic [2:0]  count;
	logic [31:0] mask;

	assign word  = s_axis_tdata[31:0];
	assign count = s_axis_tdata[34:32];

	assign s_axis_tready = !q_full;
	assign accept = s_axis_tvalid && s_axis_tready;
	// a word outside a message changes nothing
	assign keep   = s_axis_tuser || in_msg_q;
	assign q_push = accept && keep;

	always_comb begin
		case (count)
			3'd1:    mask = 32'h0000_00FF;
			3'd2:    mask = 32'h0000_FFFF;
			3'd3:    mask = 32'h00FF_FFFF;
			default: mask = 32'hFFFF_FFFF;
		endcase
	end

	always_comb begin
		q_entry.first  = s_axis_tuser;
		q_entry.last   = s_axis_tlast;
		q_entry.length = s_axis_tdata[66:35];
		q_entry.word   = word;
		if (!s_axis_tlast || count >= 3'd4) begin
			q_entry.op = OP_FULL;
		end else if (count != 3'd0) begin
			// only a short last word loses its upper bytes
			q_entry.op   = OP_TAIL;
			q_entry.word = word & mask;
		end else begin
			q_entry.op = OP_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_msg_q <= 1'b0;
		end else if (q_push) begin
			in_msg_q <= !s_axis_tlast;
		end
	end

endmodule
`default_nettype wire

// ===== src/m2h_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m2h_fifo
// Short register queue between the front and the hash engine.
// ----------------------------------------------------------------------------
module m2h_fifo #(
	parameter int DEPTH = m2h_pkg::FIFO_DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire m2h_pkg::m2h_entry_t wr_entry,
	input  wire logic                pop,
	output m2h_pkg::m2h_entry_t      rd_entry,
	output logic                     full,
	output logic                     empty
);
	import m2h_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	m2h_entry_t    mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full     = cnt_q == CW'(DEPTH);
	assign empty    = cnt_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign rd_entry = mem_q[rd_ptr_q];

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/m2h_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m2h_back
// Hash engine: a sequencer around one 32x32 constant multiplier that mixes
// words into the running hash, folds tails and finalizes each message.
// ----------------------------------------------------------------------------
module m2h_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire m2h_pkg::m2h_entry_t q_entry,
	input  wire logic                q_empty,
	output logic                     q_pop,
	output logic                     m_axis_tvalid,
	input  wire logic                m_axis_tready,
	output logic [31:0]              m_axis_tdata   // hash_value
);
	import m2h_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_K1   = 3'd1;
	localparam logic [2:0] ST_K2   = 3'd2;
	localparam logic [2:0] ST_H    = 3'd3;
	localparam logic [2:0] ST_TAIL = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	logic [2:0]  state_q;
	logic [31:0] h_q;
	logic [31:0] k_q;
	logic        last_q;
	logic        out_valid_q;
	logic [31:0] out_q;
	logic [31:0] mul_a;
	logic [31:0] prod;
	logic        out_free;

	assign q_pop         = (state_q == ST_IDLE) && !q_empty;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	always_comb begin
		case (state_q)
			ST_K1:   mul_a = k_q;
			ST_K2:   mul_a = k_q ^ (k_q >> SHIFT_MIX);
			ST_H:    mul_a = h_q;
			ST_TAIL: mul_a = h_q ^ k_q;
			ST_FIN:  mul_a = h_q ^ (h_q >> SHIFT_FIN_A);
			default: mul_a = h_q;
		endcase
	end

	assign prod = mul_a * MUL_K;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					k_q    <= q_entry.word;
					last_q <= q_entry.last;
					if (q_entry.first) begin
						h_q <= q_entry.length;
					end
				end
			end
			ST_K1, ST_K2: k_q <= prod;
			ST_H:         h_q <= prod ^ k_q;
			ST_TAIL:      h_q <= prod;
			ST_FIN: begin
				if (out_free) begin
					out_q <= prod ^ (prod >> SHIFT_FIN_B);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						case (q_entry.op)
							OP_FULL: state_q <= ST_K1;
							OP_TAIL: state_q <= ST_TAIL;
							default: state_q <= q_entry.last ? ST_FIN : ST_IDLE;
						endcase
					end
				end
				ST_K1:   state_q <= ST_K2;
				ST_K2:   state_q <= ST_H;
				ST_H,
				ST_TAIL: state_q <= last_q ? ST_FIN : ST_IDLE;
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== src/murmur2_hash32_stream_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// murmur2_hash32_stream_top
// Streaming 32-bit MurmurHash2 (seed zero), one hash per message.
// ----------------------------------------------------------------------------
// Words enter on s_axis; a word with tuser set opens a message and seeds the
// hash with total_length, tlast closes it and one hash leaves on m_axis.
// Words outside a message are dropped. The front takes one word per cycle,
// while the queue is not full, into a FIFO_DEPTH entry queue; the engine
// behind it shares a single 32x32 multiplier, so a full word passes through
// the states K1, K2 and H, a tail through TAIL, and any last word, even an
// empty one, leads to the finalization state FIN. Sustained throughput is
// set by that multiplier sequence; the queue absorbs short bursts and output
// stalls. The result waits in an output register while the next words are taken in.
module murmur2_hash32_stream_top #(
	parameter int FIFO_DEPTH = m2h_pkg::FIFO_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [71:0] s_axis_tdata,  // [31:0] data_word, [34:32] byte_count,
	                                        // [66:35] total_length, rest zero
	input  wire logic        s_axis_tuser,  // first_item
	input  wire logic        s_axis_tlast,  // last_item
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata   // hash_value
);
	import m2h_pkg::*;

	m2h_entry_t push_entry;
	m2h_entry_t pop_entry;
	logic       push;
	logic       pop;
	logic       full;
	logic       empty;

	m2h_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.q_full        (full),
		.q_push        (push),
		.q_entry       (push_entry)
	);

	m2h_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (push_entry),
		.pop      (pop),
		.rd_entry (pop_entry),
		.full     (full),
		.empty    (empty)
	);

	m2h_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_entry       (pop_entry),
		.q_empty       (empty),
		.q_pop         (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule
`default_nettype wire
